// ----- src/bss_pkg.sv -----
package bss_pkg;

	// Confirmation ticks in check and tick limit in prepare
	localparam logic [1:0] CONFIRM_TICKS   = 2'd2;
	localparam logic [2:0] PREPARE_TIMEOUT = 3'd5;

	// Reset value of the very-low voltage limit (mV)
	localparam logic [15:0] VERY_LOW_RESET = 16'd2500;

	// Sleep modes
	localparam logic [1:0] MODE_NONE   = 2'd0;
	localparam logic [1:0] MODE_HICCUP = 2'd1;
	localparam logic [1:0] MODE_NORMAL = 2'd2;
	localparam logic [1:0] MODE_DEEP   = 2'd3;

	// Register indexes
	localparam logic [1:0] REG_VOLT_NORMAL   = 2'd0;
	localparam logic [1:0] REG_VOLT_LOW      = 2'd1;
	localparam logic [1:0] REG_VOLT_VERY_LOW = 2'd2;
	localparam logic [1:0] REG_RTC_WAKE      = 2'd3;

	// Configuration registers
	typedef struct packed {
		logic [15:0] volt_normal_limit;
		logic [15:0] volt_low_limit;
		logic [15:0] volt_very_low_limit;
		logic [15:0] rtc_wake_time;
	} cfg_t;

	// Registered request
	typedef struct packed {
		logic        opcode;
		logic [2:0]  force_levels;
		logic [4:0]  fault_flags;
		logic        test_sleep;
		logic [15:0] cell_min_mv;
		logic        charging;
		logic        discharging;
	} req_t;

	// Evaluation of one request
	typedef struct packed {
		logic       cond_hold;
		logic [1:0] mode;
	} eval_t;

	// One result
	typedef struct packed {
		logic [15:0] wake_total;
		logic [15:0] sleep_total;
		logic        sleeping;
		logic        clear_pulse;
		logic        enter_pulse;
		logic [1:0]  sel_mode;
		logic [2:0]  seq_state;
	} result_t;

endpackage

// ----- src/bss_eval.sv -----
// Sleep condition and mode priority for one request
module bss_eval (
	input  bss_pkg::req_t  req,
	input  bss_pkg::cfg_t  cfg,
	output bss_pkg::eval_t ev
);

	logic flags_any;
	logic le_very_low;
	logic le_low;
	logic le_normal;

	// Voltage compares
	assign flags_any   = (req.force_levels != 3'd0) || (req.fault_flags != 5'd0) || req.test_sleep;
	assign le_very_low = req.cell_min_mv <= cfg.volt_very_low_limit;
	assign le_low      = req.cell_min_mv <= cfg.volt_low_limit;
	assign le_normal   = req.cell_min_mv <= cfg.volt_normal_limit;

	// Condition to leave idle / stay in check
	assign ev.cond_hold = flags_any || le_very_low || (le_low && !req.charging)
		|| (le_normal && !req.charging && !req.discharging);

	// Mode by priority
	always_comb begin
		if (req.force_levels[0]) begin
			ev.mode = bss_pkg::MODE_HICCUP;
		end else if (req.force_levels[1]) begin
			ev.mode = bss_pkg::MODE_NORMAL;
		end else if (req.force_levels[2]) begin
			ev.mode = bss_pkg::MODE_DEEP;
		end else if (req.fault_flags != 5'd0) begin
			ev.mode = bss_pkg::MODE_DEEP;
		end else if (req.test_sleep) begin
			ev.mode = bss_pkg::MODE_NORMAL;
		end else if (le_very_low) begin
			ev.mode = bss_pkg::MODE_DEEP;
		end else if (le_low && !req.charging) begin
			ev.mode = bss_pkg::MODE_DEEP;
		end else if (le_normal) begin
			if (req.charging || req.discharging) begin
				ev.mode = bss_pkg::MODE_NONE;
			end else if (cfg.rtc_wake_time != 16'd0) begin
				ev.mode = bss_pkg::MODE_HICCUP;
			end else begin
				ev.mode = bss_pkg::MODE_NORMAL;
			end
		end else begin
			ev.mode = bss_pkg::MODE_NONE;
		end
	end

endmodule

// ----- src/bss_core.sv -----
// Sequencer state and result register
module bss_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             opcode,
	input  bss_pkg::eval_t   ev,
	input  logic             res_ready,
	output logic             res_valid,
	output bss_pkg::result_t res
);

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_CHECK   = 3'd1,
		PH_PREPARE = 3'd2,
		PH_ENTER   = 3'd3,
		PH_WAKEUP  = 3'd4,
		PH_RECOVER = 3'd5
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [1:0]  confirm_q, confirm_n, confirm_inc;
	logic [2:0]  prepare_q, prepare_n, prepare_inc;
	logic [1:0]  mode_q, mode_n;
	logic        asleep_q, asleep_n;
	logic [15:0] entry_cnt_q, entry_cnt_n;
	logic [15:0] wake_cnt_q, wake_cnt_n;
	logic        enter_n, clear_n;

	// Saturating tick counters
	assign confirm_inc = (confirm_q != 2'd3) ? confirm_q + 2'd1 : confirm_q;
	assign prepare_inc = (prepare_q != 3'd7) ? prepare_q + 3'd1 : prepare_q;

	// Next state for one request
	always_comb begin
		phase_n     = phase_q;
		confirm_n   = confirm_q;
		prepare_n   = prepare_q;
		mode_n      = mode_q;
		asleep_n    = asleep_q;
		entry_cnt_n = entry_cnt_q;
		wake_cnt_n  = wake_cnt_q;
		enter_n     = 1'b0;
		clear_n     = 1'b0;
		if (opcode) begin
			// wakeup event, taken in any phase
			wake_cnt_n = wake_cnt_q + 16'd1;
			asleep_n   = 1'b0;
			mode_n     = bss_pkg::MODE_NONE;
			clear_n    = 1'b1;
			phase_n    = PH_RECOVER;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (ev.cond_hold) begin
						phase_n   = PH_CHECK;
						confirm_n = 2'd0;
					end
				end
				PH_CHECK: begin
					confirm_n = confirm_inc;
					if (confirm_inc >= bss_pkg::CONFIRM_TICKS) begin
						phase_n   = PH_PREPARE;
						prepare_n = 3'd0;
					end
					// condition drop wins over confirmation
					if (!ev.cond_hold) begin
						phase_n = PH_IDLE;
					end
				end
				PH_PREPARE: begin
					prepare_n = prepare_inc;
					mode_n    = ev.mode;
					if (ev.mode != bss_pkg::MODE_NONE) begin
						phase_n = PH_ENTER;
					end
					// timeout wins over entry
					if (prepare_inc >= bss_pkg::PREPARE_TIMEOUT) begin
						phase_n = PH_IDLE;
					end
				end
				PH_ENTER: begin
					asleep_n    = 1'b1;
					entry_cnt_n = entry_cnt_q + 16'd1;
					enter_n     = 1'b1;
					phase_n     = PH_WAKEUP;
				end
				PH_WAKEUP: begin
					phase_n = PH_RECOVER;
				end
				PH_RECOVER: begin
					clear_n = 1'b1;
					phase_n = PH_IDLE;
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase
		end
	end

	// State and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			confirm_q   <= 2'd0;
			prepare_q   <= 3'd0;
			mode_q      <= bss_pkg::MODE_NONE;
			asleep_q    <= 1'b0;
			entry_cnt_q <= 16'd0;
			wake_cnt_q  <= 16'd0;
			res_valid   <= 1'b0;
		end else begin
			if (advance) begin
				phase_q         <= phase_n;
				confirm_q       <= confirm_n;
				prepare_q       <= prepare_n;
				mode_q          <= mode_n;
				asleep_q        <= asleep_n;
				entry_cnt_q     <= entry_cnt_n;
				wake_cnt_q      <= wake_cnt_n;
				res_valid       <= 1'b1;
				res.seq_state   <= phase_n;
				res.sel_mode    <= mode_n;
				res.enter_pulse <= enter_n;
				res.clear_pulse <= clear_n;
				res.sleeping    <= asleep_n;
				res.sleep_total <= entry_cnt_n;
				res.wake_total  <= wake_cnt_n;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

endmodule

// ----- src/battery_sleep_sequencer.sv -----
// Channel   Dir  Payload
// s_axis    in   tuser: opcode; tdata: force, faults, test, cell mV, charge, discharge
// m_axis    out  tdata: state, mode, enter, clear, sleeping, sleep/wake totals
// cfg       in   cfg_we, cfg_index, cfg_data (16 bit limits and wake time)
//
// One request per cycle sustained while m_axis is ready; each request is registered
// in the input register on s_axis accept, then evaluated with the state update into
// the result register when the input register advances.
// arst_n clears the sequencer, the counters and the limits (very-low limit 2500 mV).
// A stall on m_axis holds the result and the input register; s_axis then fills
// one request deep and drops tready.
module battery_sleep_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // force_levels[2:0], fault_flags[7:3], test_sleep[8],
	                                   // cell_min_mv[24:9], charge_amps[40:25],
	                                   // discharge_amps[56:41], zero fill[63:57]
	input  logic [0:0]  s_axis_tuser,  // opcode[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // seq_state[2:0], sel_mode[4:3], enter_pulse[5],
	                                   // clear_pulse[6], sleeping[7], sleep_total[23:8],
	                                   // wake_total[39:24]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	bss_pkg::cfg_t    cfg_q;
	bss_pkg::req_t    req_s1;
	logic             valid_s1;
	logic             advance;
	bss_pkg::eval_t   ev;
	bss_pkg::result_t res;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volt_normal_limit   <= 16'd0;
			cfg_q.volt_low_limit      <= 16'd0;
			cfg_q.volt_very_low_limit <= bss_pkg::VERY_LOW_RESET;
			cfg_q.rtc_wake_time       <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bss_pkg::REG_VOLT_NORMAL:   cfg_q.volt_normal_limit   <= cfg_data;
				bss_pkg::REG_VOLT_LOW:      cfg_q.volt_low_limit      <= cfg_data;
				bss_pkg::REG_VOLT_VERY_LOW: cfg_q.volt_very_low_limit <= cfg_data;
				bss_pkg::REG_RTC_WAKE:      cfg_q.rtc_wake_time       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register moves on when the result register is free or draining
	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1.opcode       <= s_axis_tuser[0];
			req_s1.force_levels <= s_axis_tdata[2:0];
			req_s1.fault_flags  <= s_axis_tdata[7:3];
			req_s1.test_sleep   <= s_axis_tdata[8];
			req_s1.cell_min_mv  <= s_axis_tdata[24:9];
			req_s1.charging     <= s_axis_tdata[40:25] != 16'd0;
			req_s1.discharging  <= s_axis_tdata[56:41] != 16'd0;
		end
	end

	bss_eval u_eval (
		.req (req_s1),
		.cfg (cfg_q),
		.ev  (ev)
	);

	bss_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.opcode    (req_s1.opcode),
		.ev        (ev),
		.res_ready (m_axis_tready),
		.res_valid (m_axis_tvalid),
		.res       (res)
	);

	assign m_axis_tdata = res;

	// Sleep entry always lands in the wakeup phase
	a_enter_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[2:0] == 3'd4)
		else $error("enter pulse outside wakeup phase");

	// Clear only on recover ticks (to idle) or wakeup events (to recover)
	a_clear_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[6]
		|-> (m_axis_tdata[2:0] == 3'd0 || m_axis_tdata[2:0] == 3'd5))
		else $error("clear pulse in wrong phase");

	// A held request stays while the result register is stalled
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(req_s1))
		else $error("input register lost a request under stall");

	// Every advance yields a result
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_axis_tvalid)
		else $error("result missing after advance");

endmodule

// ----- test/tb_top.sv -----
module tb_top;

	localparam int CYCLE_LIMIT = 400000;

	// Request opcodes (tuser)
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_WAKE = 1'b1;

	// Sequencer phases as reported in seq_state
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_CHECK   = 3'd1,
		PH_PREPARE = 3'd2,
		PH_ENTER   = 3'd3,
		PH_WAKEUP  = 3'd4,
		PH_RECOVER = 3'd5
	} seq_phase_t;

	// One request as the sender sees it
	typedef struct packed {
		logic        op;
		logic [2:0]  force_lv;
		logic [4:0]  faults;
		logic        test_req;
		logic [15:0] cell_mv;
		logic [15:0] chg_amps;
		logic [15:0] dis_amps;
	} pack_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;  // force_levels, fault_flags, test_sleep, cell_min_mv,
	                                 // charge_amps, discharge_amps, zero fill
	logic [0:0]  s_axis_tuser = '0;  // opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;       // seq_state, sel_mode, enter_pulse, clear_pulse,
	                                 // sleeping, sleep_total, wake_total
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = bss_pkg::REG_VOLT_NORMAL;
	logic [15:0] cfg_data = '0;

	battery_sleep_sequencer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the sequencer: limits and state
	bss_pkg::cfg_t lim;
	seq_phase_t    ph;
	logic [1:0]    confirm_cnt;
	logic [2:0]    prepare_cnt;
	logic [1:0]    mode_sel;
	logic          asleep;
	logic [15:0]   entry_cnt;
	logic [15:0]   wake_cnt;

	bss_pkg::result_t status_q[$];
	int               errors = 0;
	int               burst_left = 0;
	int unsigned      cycle_count = 0;

	task automatic reset_shadow();
		lim.volt_normal_limit   = '0;
		lim.volt_low_limit      = '0;
		lim.volt_very_low_limit = bss_pkg::VERY_LOW_RESET;
		lim.rtc_wake_time       = '0;
		ph          = PH_IDLE;
		confirm_cnt = '0;
		prepare_cnt = '0;
		mode_sel    = bss_pkg::MODE_NONE;
		asleep      = 1'b0;
		entry_cnt   = '0;
		wake_cnt    = '0;
	endtask

	// Any sleep reason present in this request
	function automatic logic sleep_wanted(pack_req_t r);
		logic chg;
		logic dis;
		chg = (r.chg_amps != '0);
		dis = (r.dis_amps != '0);
		if (r.force_lv != '0 || r.faults != '0 || r.test_req)
			return 1'b1;
		if (r.cell_mv <= lim.volt_very_low_limit)
			return 1'b1;
		if (r.cell_mv <= lim.volt_low_limit && !chg)
			return 1'b1;
		return (r.cell_mv <= lim.volt_normal_limit && !chg && !dis);
	endfunction

	// Mode choice by priority: force levels, faults, test, then voltage
	function automatic logic [1:0] pick_mode_prio(pack_req_t r);
		logic chg;
		logic dis;
		chg = (r.chg_amps != '0);
		dis = (r.dis_amps != '0);
		if (r.force_lv[0]) return bss_pkg::MODE_HICCUP;
		if (r.force_lv[1]) return bss_pkg::MODE_NORMAL;
		if (r.force_lv[2]) return bss_pkg::MODE_DEEP;
		if (r.faults != '0) return bss_pkg::MODE_DEEP;
		if (r.test_req) return bss_pkg::MODE_NORMAL;
		if (r.cell_mv <= lim.volt_very_low_limit) return bss_pkg::MODE_DEEP;
		if (r.cell_mv <= lim.volt_low_limit && !chg) return bss_pkg::MODE_DEEP;
		if (r.cell_mv <= lim.volt_normal_limit) begin
			if (chg || dis) return bss_pkg::MODE_NONE;
			return (lim.rtc_wake_time != '0) ? bss_pkg::MODE_HICCUP : bss_pkg::MODE_NORMAL;
		end
		return bss_pkg::MODE_NONE;
	endfunction

	// One step of the sequencer; returns the status it reports
	function automatic bss_pkg::result_t advance_sequencer(pack_req_t r);
		bss_pkg::result_t res;
		res = '0;
		if (r.op == OP_WAKE) begin
			wake_cnt = wake_cnt + 16'd1;
			asleep = 1'b0;
			mode_sel = bss_pkg::MODE_NONE;
			res.clear_pulse = 1'b1;
			ph = PH_RECOVER;
		end else begin
			case (ph)
				PH_IDLE: begin
					if (sleep_wanted(r)) begin
						ph = PH_CHECK;
						confirm_cnt = '0;
					end
				end
				PH_CHECK: begin
					// a dropped condition wins over confirmation
					if (confirm_cnt != '1) confirm_cnt = confirm_cnt + 2'd1;
					if (confirm_cnt >= bss_pkg::CONFIRM_TICKS) begin
						ph = PH_PREPARE;
						prepare_cnt = '0;
					end
					if (!sleep_wanted(r)) ph = PH_IDLE;
				end
				PH_PREPARE: begin
					// timeout wins over a valid mode, the mode is kept
					if (prepare_cnt != '1) prepare_cnt = prepare_cnt + 3'd1;
					mode_sel = pick_mode_prio(r);
					if (mode_sel != bss_pkg::MODE_NONE) ph = PH_ENTER;
					if (prepare_cnt >= bss_pkg::PREPARE_TIMEOUT) ph = PH_IDLE;
				end
				PH_ENTER: begin
					asleep = 1'b1;
					entry_cnt = entry_cnt + 16'd1;
					res.enter_pulse = 1'b1;
					ph = PH_WAKEUP;
				end
				PH_WAKEUP: ph = PH_RECOVER;
				PH_RECOVER: begin
					res.clear_pulse = 1'b1;
					ph = PH_IDLE;
				end
				default: ph = PH_IDLE;
			endcase
		end
		res.seq_state   = ph;
		res.sel_mode    = mode_sel;
		res.sleeping    = asleep;
		res.sleep_total = entry_cnt;
		res.wake_total  = wake_cnt;
		return res;
	endfunction

	function automatic pack_req_t make_req(logic op, logic [2:0] force_lv, logic [4:0] faults,
			logic test_req, logic [15:0] cell_mv, logic [15:0] chg_amps,
			logic [15:0] dis_amps);
		pack_req_t r;
		r.op       = op;
		r.force_lv = force_lv;
		r.faults   = faults;
		r.test_req = test_req;
		r.cell_mv  = cell_mv;
		r.chg_amps = chg_amps;
		r.dis_amps = dis_amps;
		return r;
	endfunction

	// No flags, high cell, both currents flowing
	function automatic pack_req_t quiet_req();
		return make_req(OP_TICK, 3'd0, 5'd0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
	endfunction

	// Cell voltage often near one of the limits, else zero, full scale or random
	function automatic logic [15:0] rand_cell();
		logic [15:0] near;
		near = 16'($urandom_range(0, 2)) - 16'd1;
		case ($urandom_range(0, 7))
			0: return lim.volt_normal_limit + near;
			1: return lim.volt_low_limit + near;
			2: return lim.volt_very_low_limit + near;
			3: return 16'd0;
			4: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [15:0] rand_amps();
		case ($urandom_range(0, 5))
			0, 1, 2: return 16'd0;
			3: return 16'hFFFF;
			4: return 16'd1;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic pack_req_t rand_req();
		pack_req_t r;
		r.op       = OP_TICK;
		r.force_lv = ($urandom_range(0, 9) < 7) ? 3'd0 : 3'($urandom_range(1, 7));
		r.faults   = ($urandom_range(0, 9) < 8) ? 5'd0 : 5'($urandom_range(1, 31));
		r.test_req = ($urandom_range(0, 9) == 0);
		r.cell_mv  = rand_cell();
		r.chg_amps = rand_amps();
		r.dis_amps = rand_amps();
		return r;
	endfunction

	// Send one request in bursts with random gaps; predict on accept
	task automatic send_req(input pack_req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				@(negedge clk) s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= r.op;
		s_axis_tdata  <= {7'd0, r.dis_amps, r.chg_amps, r.cell_mv, r.test_req, r.faults,
			r.force_lv};
		do @(posedge clk); while (!s_axis_tready);
		status_q.push_back(advance_sequencer(r));
		burst_left--;
	endtask

	// Stop sending and wait for every outstanding result
	task automatic drain();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			bss_pkg::REG_VOLT_NORMAL:   lim.volt_normal_limit = val;
			bss_pkg::REG_VOLT_LOW:      lim.volt_low_limit = val;
			bss_pkg::REG_VOLT_VERY_LOW: lim.volt_very_low_limit = val;
			bss_pkg::REG_RTC_WAKE:      lim.rtc_wake_time = val;
		endcase
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	task automatic set_limits(input logic [15:0] normal_mv, input logic [15:0] low_mv,
			input logic [15:0] very_low_mv, input logic [15:0] rtc);
		drain();
		write_reg(bss_pkg::REG_VOLT_NORMAL, normal_mv);
		write_reg(bss_pkg::REG_VOLT_LOW, low_mv);
		write_reg(bss_pkg::REG_VOLT_VERY_LOW, very_low_mv);
		write_reg(bss_pkg::REG_RTC_WAKE, rtc);
	endtask

	// Mostly held requests so the sequence walks through to sleep, some noise
	task automatic random_traffic(input int n_items);
		pack_req_t r;
		int sent;
		int hold;
		sent = 0;
		while (sent < n_items) begin
			r = rand_req();
			if ($urandom_range(0, 9) < 8) begin
				hold = $urandom_range(1, 9);
				repeat (hold) begin
					if ($urandom_range(0, 15) == 0) r.cell_mv = rand_cell();
					send_req(r);
					sent++;
				end
				if ($urandom_range(0, 5) == 0) begin
					r.op = OP_WAKE;
					send_req(r);
					sent++;
				end
			end else begin
				if ($urandom_range(0, 1) == 0) r.op = OP_WAKE;
				send_req(r);
				sent++;
			end
		end
	endtask

	// Default limits: voltage boundary, drop in check, force priority, sleep and wake
	task automatic test_basic_sleep();
		pack_req_t q;
		q = quiet_req();
		send_req(q);
		send_req(make_req(OP_TICK, 3'd0, 5'd0, 1'b0, bss_pkg::VERY_LOW_RESET,
			16'hFFFF, 16'hFFFF));
		send_req(q);
		repeat (3) send_req(make_req(OP_TICK, 3'd1, 5'd0, 1'b0, 16'hFFFF, 16'd0, 16'd0));
		send_req(make_req(OP_TICK, 3'd7, 5'd0, 1'b0, 16'hFFFF, 16'd0, 16'd0));
		send_req(q);
		send_req(make_req(OP_WAKE, 3'd7, 5'd31, 1'b1, 16'd0, 16'd0, 16'd0));
		// recover tick ignores the flags
		send_req(make_req(OP_TICK, 3'd7, 5'd31, 1'b1, 16'd0, 16'd0, 16'd0));
	endtask

	// Wakeup event taken in idle and in check
	task automatic test_wake_anywhere();
		send_req(make_req(OP_WAKE, 3'd0, 5'd0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_req(quiet_req());
		send_req(make_req(OP_TICK, 3'd0, 5'd0, 1'b0, 16'd0, 16'hFFFF, 16'hFFFF));
		send_req(make_req(OP_WAKE, 3'd0, 5'd0, 1'b0, 16'd0, 16'hFFFF, 16'hFFFF));
		send_req(quiet_req());
	endtask

	// Prepare runs out while the last request would pick a mode
	task automatic test_prepare_timeout();
		repeat (3) send_req(make_req(OP_TICK, 3'd0, 5'd31, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		repeat (4) send_req(quiet_req());
		send_req(make_req(OP_TICK, 3'd2, 5'd0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
	endtask

	// Random traffic under several limit settings, extremes included
	task automatic test_limit_sweep();
		random_traffic(120);
		set_limits(16'd0, 16'd0, 16'd0, 16'd0);
		random_traffic(120);
		set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_traffic(120);
		set_limits(16'd4000, 16'd3500, 16'd3000, 16'd0);
		random_traffic(120);
		set_limits(16'd3000, 16'd3800, 16'd3400, 16'($urandom_range(1, 65535)));
		random_traffic(120);
		set_limits(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 1)));
		random_traffic(120);
		set_limits(16'd3600, 16'd3300, 16'd2800, 16'hFFFF);
		random_traffic(100);
	endtask

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Receiver stall pattern: free running, random, sparse, periodic
	logic [7:0] stall_tick = '0;
	always @(negedge clk) begin
		stall_tick <= stall_tick + 8'd1;
		case (stall_tick[7:6])
			2'd0: m_axis_tready <= 1'b1;
			2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2'd2: m_axis_tready <= (stall_tick[1:0] == 2'b00);
			default: m_axis_tready <= (stall_tick[3:0] < 4'd9);
		endcase
	end

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin : check_result
		bss_pkg::result_t got;
		bss_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (status_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, got);
				errors++;
			end else begin
				want = status_q.pop_front();
				compare_field("seq_state", 32'(want.seq_state), 32'(got.seq_state));
				compare_field("sel_mode", 32'(want.sel_mode), 32'(got.sel_mode));
				compare_field("enter_pulse", 32'(want.enter_pulse), 32'(got.enter_pulse));
				compare_field("clear_pulse", 32'(want.clear_pulse), 32'(got.clear_pulse));
				compare_field("sleeping", 32'(want.sleeping), 32'(got.sleeping));
				compare_field("sleep_total", 32'(want.sleep_total), 32'(got.sleep_total));
				compare_field("wake_total", 32'(want.wake_total), 32'(got.wake_total));
			end
		end
	end

	// Run limit
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		reset_shadow();
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_basic_sleep();
		test_wake_anywhere();
		test_prepare_timeout();
		test_limit_sweep();
		drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && status_q.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
